@@ rtl/mks_pkg.sv @@
package mks_pkg;

    // Defaults for the top-level parameters.
    localparam int DEF_MAX_COLS    = 1024;
    localparam int DEF_MAX_KERNEL  = 5;
    localparam int DEF_SAMPLE_BITS = 16;

    localparam int QUEUE_DEPTH = 4;
    localparam int WEIGHT_FRAC = 14;

    // Widths of the effective configuration as it is handed to the sub-blocks.
    localparam int CFG_ROW_W = 16;
    localparam int CFG_COL_W = 14;
    localparam int HALF_W    = 3;
    localparam int LAG_W     = 16;
    localparam int CFG_IDX_W = 3;
    localparam int CFG_DAT_W = 16;

    // Input commands.
    localparam logic [1:0] CMD_WEIGHT = 2'd0;
    localparam logic [1:0] CMD_PIXEL  = 2'd1;
    localparam logic [1:0] CMD_FLUSH  = 2'd2;

    // Operations carried through the queue.
    localparam logic [1:0] OP_NONE   = 2'd0;
    localparam logic [1:0] OP_WEIGHT = 2'd1;
    localparam logic [1:0] OP_WRITE  = 2'd2;

    // Configuration register indexes.
    localparam logic [CFG_IDX_W-1:0] REG_ROWS   = 3'd0;
    localparam logic [CFG_IDX_W-1:0] REG_COLS   = 3'd1;
    localparam logic [CFG_IDX_W-1:0] REG_HALF_R = 3'd2;
    localparam logic [CFG_IDX_W-1:0] REG_HALF_C = 3'd3;
    localparam logic [CFG_IDX_W-1:0] REG_NORM   = 3'd4;

    typedef struct packed {
        logic [CFG_ROW_W-1:0] rows;
        logic [CFG_COL_W-1:0] cols;
        logic [HALF_W-1:0]    half_r;
        logic [HALF_W-1:0]    half_c;
        logic                 norm;
        logic [LAG_W-1:0]     lag;
    } cfg_t;

endpackage

@@ rtl/mks_queue.sv @@
module mks_queue
    import mks_pkg::*;
#(
    parameter int WIDTH = 8,
    parameter int DEPTH = QUEUE_DEPTH
)
(
    input  logic             clk,
    input  logic             rst_n,
    input  logic             push,
    input  logic [WIDTH-1:0] wr_data,
    input  logic             pop,
    output logic [WIDTH-1:0] rd_data,
    output logic             full,
    output logic             empty
);

    localparam int PW = (DEPTH > 1) ? $clog2(DEPTH) : 1;
    localparam int CW = $clog2(DEPTH + 1);

    logic [WIDTH-1:0] slot_reg [DEPTH];
    logic [PW-1:0]    wr_ptr_reg, rd_ptr_reg;
    logic [CW-1:0]    count_reg;

    assign full    = (count_reg == CW'(DEPTH));
    assign empty   = (count_reg == '0);
    assign rd_data = slot_reg[rd_ptr_reg];

    always_ff @(posedge clk)
    begin
        if (push)
        begin
            slot_reg[wr_ptr_reg] <= wr_data;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            wr_ptr_reg <= '0;
            rd_ptr_reg <= '0;
            count_reg  <= '0;
        end
        else
        begin
            if (push)
            begin
                wr_ptr_reg <= (wr_ptr_reg == PW'(DEPTH - 1)) ? '0 : wr_ptr_reg + 1'b1;
            end
            if (pop)
            begin
                rd_ptr_reg <= (rd_ptr_reg == PW'(DEPTH - 1)) ? '0 : rd_ptr_reg + 1'b1;
            end
            if (push && !pop)
            begin
                count_reg <= count_reg + 1'b1;
            end
            else if (pop && !push)
            begin
                count_reg <= count_reg - 1'b1;
            end
        end
    end

`ifndef NO_ASSERTIONS
    a_no_overflow: assert property (@(posedge clk) disable iff (!rst_n)
        full |-> !push || pop)
        else $error("queue written while full");
    a_no_underflow: assert property (@(posedge clk) disable iff (!rst_n)
        pop |-> !empty)
        else $error("queue read while empty");
`endif

endmodule

@@ rtl/mks_front.sv @@
module mks_front
    import mks_pkg::*;
#(
    parameter int MAX_COLS    = DEF_MAX_COLS,
    parameter int MAX_KERNEL  = DEF_MAX_KERNEL,
    parameter int SAMPLE_BITS = DEF_SAMPLE_BITS,
    parameter int EW          = 8
)
(
    input  logic                   clk,
    input  logic                   rst_n,
    input  cfg_t                   cfg,
    input  logic                   clear,
    input  logic                   in_valid,
    output logic                   in_stall,
    input  logic [1:0]             command,
    input  logic [SAMPLE_BITS-1:0] sample,
    input  logic                   sample_valid,
    input  logic [4:0]             weight_index,
    input  logic [15:0]            weight_value,
    output logic                   q_push,
    output logic [EW-1:0]          q_data,
    input  logic                   q_full
);

    localparam int COLW = $clog2(MAX_COLS);
    localparam int LW   = (MAX_KERNEL > 1) ? $clog2(MAX_KERNEL) : 1;

    logic [CFG_ROW_W-1:0] in_row_reg, in_row_next, out_row_reg, out_row_next;
    logic [COLW-1:0]      in_col_reg, in_col_next, out_col_reg, out_col_next;
    logic [LW-1:0]        in_line_reg, in_line_next, out_line_reg, out_line_next;
    logic [LAG_W:0]       pend_reg, pend_next;

    logic                 accept, complete, is_wt, is_wr, produce, last;
    logic [CFG_COL_W-1:0] in_col_inc, out_col_inc;
    logic [CFG_ROW_W:0]   out_row_inc;
    logic [1:0]           op;

    assign in_stall = q_full;
    assign accept   = in_valid && !q_full;
    assign complete = (in_row_reg >= cfg.rows);
    assign is_wt    = accept && (command == CMD_WEIGHT);
    assign is_wr    = accept && (command == CMD_PIXEL) && !complete;

    assign in_col_inc  = CFG_COL_W'(in_col_reg) + 1'b1;
    assign out_col_inc = CFG_COL_W'(out_col_reg) + 1'b1;
    assign out_row_inc = {1'b0, out_row_reg} + 1'b1;

    // A result is due once more than the lag is buffered, or whenever the frame is complete.
    assign produce = (is_wr && ((pend_reg + 1'b1) > {1'b0, cfg.lag}))
                   || (accept && complete
                       && ((command == CMD_PIXEL) || (command == CMD_FLUSH)));

    assign last = (out_row_reg == cfg.rows - 1'b1) && (out_col_inc == cfg.cols);

    assign op     = is_wt ? OP_WEIGHT : (is_wr ? OP_WRITE : OP_NONE);
    assign q_push = is_wt || is_wr || produce;
    assign q_data = {op, produce, in_line_reg, in_col_reg, sample, sample_valid,
                     weight_index, weight_value, out_row_reg, out_col_reg,
                     out_line_reg, last};

    always_comb
    begin
        in_row_next   = in_row_reg;
        in_col_next   = in_col_reg;
        in_line_next  = in_line_reg;
        out_row_next  = out_row_reg;
        out_col_next  = out_col_reg;
        out_line_next = out_line_reg;
        pend_next     = pend_reg + (LAG_W+1)'(is_wr) - (LAG_W+1)'(produce);
        if (is_wr)
        begin
            if (in_col_inc >= cfg.cols)
            begin
                in_col_next  = '0;
                in_row_next  = in_row_reg + 1'b1;
                in_line_next = (in_line_reg == LW'(MAX_KERNEL - 1)) ? '0 : in_line_reg + 1'b1;
            end
            else
            begin
                in_col_next = in_col_reg + 1'b1;
            end
        end
        if (produce)
        begin
            if (out_col_inc >= cfg.cols)
            begin
                out_col_next  = '0;
                out_row_next  = out_row_reg + 1'b1;
                out_line_next = (out_line_reg == LW'(MAX_KERNEL - 1)) ? '0 : out_line_reg + 1'b1;
                if (out_row_inc >= {1'b0, cfg.rows})
                begin
                    in_row_next   = '0;
                    in_col_next   = '0;
                    in_line_next  = '0;
                    out_row_next  = '0;
                    out_line_next = '0;
                    pend_next     = '0;
                end
            end
            else
            begin
                out_col_next = out_col_reg + 1'b1;
            end
        end
        if (clear)
        begin
            in_row_next   = '0;
            in_col_next   = '0;
            in_line_next  = '0;
            out_row_next  = '0;
            out_col_next  = '0;
            out_line_next = '0;
            pend_next     = '0;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            in_row_reg   <= '0;
            in_col_reg   <= '0;
            in_line_reg  <= '0;
            out_row_reg  <= '0;
            out_col_reg  <= '0;
            out_line_reg <= '0;
            pend_reg     <= '0;
        end
        else
        begin
            in_row_reg   <= in_row_next;
            in_col_reg   <= in_col_next;
            in_line_reg  <= in_line_next;
            out_row_reg  <= out_row_next;
            out_col_reg  <= out_col_next;
            out_line_reg <= out_line_next;
            pend_reg     <= pend_next;
        end
    end

`ifndef NO_ASSERTIONS
    a_pend_bound: assert property (@(posedge clk) disable iff (!rst_n)
        pend_reg <= {1'b0, cfg.lag} + 1'b1)
        else $error("more samples buffered than the window lag allows");
    a_flush_has_work: assert property (@(posedge clk) disable iff (!rst_n)
        complete |-> pend_reg != '0)
        else $error("frame complete with nothing pending");
    a_push_free: assert property (@(posedge clk) disable iff (!rst_n)
        q_push |-> !q_full)
        else $error("transaction pushed into a full queue");
`endif

endmodule

@@ rtl/mks_back.sv @@
module mks_back
    import mks_pkg::*;
#(
    parameter int MAX_COLS    = DEF_MAX_COLS,
    parameter int MAX_KERNEL  = DEF_MAX_KERNEL,
    parameter int SAMPLE_BITS = DEF_SAMPLE_BITS,
    parameter int EW          = 8
)
(
    input  logic                   clk,
    input  logic                   rst_n,
    input  cfg_t                   cfg,
    input  logic                   q_empty,
    input  logic [EW-1:0]          q_data,
    output logic                   q_pop,
    output logic                   out_valid,
    input  logic                   out_stall,
    output logic [SAMPLE_BITS-1:0] smoothed,
    output logic                   result_valid,
    output logic [15:0]            out_row,
    output logic [9:0]             out_col,
    output logic                   out_last
);

    localparam int SB   = SAMPLE_BITS;
    localparam int COLW = $clog2(MAX_COLS);
    localparam int LW   = (MAX_KERNEL > 1) ? $clog2(MAX_KERNEL) : 1;
    localparam int KK   = MAX_KERNEL * MAX_KERNEL;
    localparam int WI_W = $clog2(KK);
    localparam int KW   = $clog2(MAX_KERNEL);
    localparam int ACC_W = SB + 16 + $clog2(KK);
    localparam int WS_W  = 17 + $clog2(KK);
    localparam int NW    = ACC_W + 1;
    localparam int RW    = WS_W + 2;
    localparam int DCW   = $clog2(NW + 1);
    localparam logic [NW-1:0] MAXP = NW'((64'd1 << (SB - 1)) - 64'd1);

    localparam logic [2:0] S_IDLE  = 3'd0;
    localparam logic [2:0] S_SCAN  = 3'd1;
    localparam logic [2:0] S_DRAIN = 3'd2;
    localparam logic [2:0] S_DIV   = 3'd3;
    localparam logic [2:0] S_DONE  = 3'd4;

    // Queue entry fields.
    logic [1:0]     e_op;
    logic           e_prod, e_svalid, e_last;
    logic [LW-1:0]  e_wline, e_oline;
    logic [COLW-1:0] e_wcol, e_ocol;
    logic [SB-1:0]  e_sample;
    logic [4:0]     e_widx;
    logic [15:0]    e_wval, e_orow;

    assign {e_op, e_prod, e_wline, e_wcol, e_sample, e_svalid, e_widx, e_wval,
            e_orow, e_ocol, e_oline, e_last} = q_data;

    logic [2:0]  state_reg;
    logic [SB:0] mem [MAX_KERNEL][MAX_COLS];
    logic signed [15:0] wt_reg [KK];

    logic [15:0]     jrow_reg;
    logic [COLW-1:0] jcol_reg;
    logic [LW-1:0]   jline_reg;
    logic            jlast_reg;
    logic [KW-1:0]   kr_reg, kc_reg;
    logic [WI_W-1:0] widx_reg, base_reg;
    logic [1:0]      drain_reg;
    logic [DCW-1:0]  div_cnt_reg;

    logic                   p1_reg, p2_reg, any_reg, ok_reg, neg_reg;
    logic [SB:0]            mem_q_reg;
    logic signed [15:0]     w_q_reg, w2_reg;
    logic signed [SB+15:0]  prod_reg;
    logic signed [ACC_W-1:0] acc_reg;
    logic signed [WS_W-1:0] wsum_reg;
    logic [NW-1:0]          num_reg;
    logic [WS_W:0]          d_reg;
    logic [RW-1:0]          rem_reg;

    logic                   out_valid_reg, rv_reg, last_o_reg;
    logic [SB-1:0]          sm_reg;
    logic [15:0]            row_o_reg;
    logic [COLW-1:0]        col_o_reg;

    logic [WI_W+4:0] widx_ext;
    logic            wt_ok;
    assign widx_ext = {{WI_W{1'b0}}, e_widx};
    assign wt_ok    = (32'(e_widx) < 32'(KK));

    assign q_pop = (state_reg == S_IDLE) && !q_empty;

    // Window position to store address.
    logic [17:0]          row_t;
    logic [CFG_COL_W+1:0] col_t;
    logic [LW+1:0]        line_t, line_t1, line_t2;
    logic                 in_win, last_pos;
    logic [LW-1:0]        rd_line;
    logic [COLW-1:0]      rd_col;

    assign row_t  = {2'b00, jrow_reg} + 18'(kr_reg) - 18'(cfg.half_r);
    assign col_t  = (CFG_COL_W+2)'(jcol_reg) + (CFG_COL_W+2)'(kc_reg)
                  - (CFG_COL_W+2)'(cfg.half_c);
    assign in_win = !row_t[17] && (row_t[16:0] < {1'b0, cfg.rows})
                  && !col_t[CFG_COL_W+1] && (col_t[CFG_COL_W:0] < {1'b0, cfg.cols});
    assign line_t  = (LW+2)'(jline_reg) + (LW+2)'(MAX_KERNEL) - (LW+2)'(cfg.half_r)
                   + (LW+2)'(kr_reg);
    assign line_t1 = (line_t >= (LW+2)'(MAX_KERNEL)) ? line_t - (LW+2)'(MAX_KERNEL) : line_t;
    assign line_t2 = (line_t1 >= (LW+2)'(MAX_KERNEL)) ? line_t1 - (LW+2)'(MAX_KERNEL) : line_t1;
    assign rd_line = in_win ? line_t2[LW-1:0] : '0;
    assign rd_col  = in_win ? col_t[COLW-1:0] : '0;
    assign last_pos = ((HALF_W+1)'(kr_reg) == {cfg.half_r, 1'b0})
                   && ((HALF_W+1)'(kc_reg) == {cfg.half_c, 1'b0});

    // Sign and magnitude set-up for the final scaling.
    logic [ACC_W-1:0] mag;
    logic [WS_W-1:0]  den;
    logic             setup_ok, setup_neg;
    assign mag       = acc_reg[ACC_W-1] ? ACC_W'(-acc_reg) : ACC_W'(acc_reg);
    assign den       = wsum_reg[WS_W-1] ? WS_W'(-wsum_reg) : WS_W'(wsum_reg);
    assign setup_ok  = any_reg && !(cfg.norm && (wsum_reg == '0));
    assign setup_neg = acc_reg[ACC_W-1] ^ (cfg.norm && wsum_reg[WS_W-1]);

    logic [RW-1:0] rem_sh;
    assign rem_sh = {rem_reg[RW-2:0], num_reg[NW-1]};

    // Saturation of the quotient.
    logic [SB-1:0] sat;
    logic [NW-1:0] neg_q;
    assign neg_q = -num_reg;
    always_comb
    begin
        if (!ok_reg)
        begin
            sat = '0;
        end
        else if (neg_reg)
        begin
            sat = (num_reg > MAXP + 1'b1) ? {1'b1, {(SB-1){1'b0}}} : neg_q[SB-1:0];
        end
        else
        begin
            sat = (num_reg > MAXP) ? {1'b0, {(SB-1){1'b1}}} : num_reg[SB-1:0];
        end
    end

    logic load_out;
    assign load_out = (state_reg == S_DONE) && (!out_valid_reg || !out_stall);

    always_ff @(posedge clk)
    begin
        if (q_pop && (e_op == OP_WRITE))
        begin
            mem[e_wline][e_wcol] <= {e_svalid, e_sample};
        end
        mem_q_reg <= mem[rd_line][rd_col];
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            for (int i = 0; i < KK; i++)
            begin
                wt_reg[i] <= '0;
            end
        end
        else if (q_pop && (e_op == OP_WEIGHT) && wt_ok)
        begin
            wt_reg[widx_ext[WI_W-1:0]] <= e_wval;
        end
    end

    // Multiply-accumulate datapath.
    always_ff @(posedge clk)
    begin
        w_q_reg  <= wt_reg[widx_reg];
        prod_reg <= w_q_reg * $signed(mem_q_reg[SB-1:0]);
        w2_reg   <= w_q_reg;
        if (q_pop && e_prod)
        begin
            acc_reg  <= '0;
            wsum_reg <= '0;
        end
        else if (p2_reg)
        begin
            acc_reg  <= acc_reg + ACC_W'(prod_reg);
            wsum_reg <= wsum_reg + WS_W'(w2_reg);
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg     <= S_IDLE;
            p1_reg        <= 1'b0;
            p2_reg        <= 1'b0;
            any_reg       <= 1'b0;
            out_valid_reg <= 1'b0;
            kr_reg        <= '0;
            kc_reg        <= '0;
            widx_reg      <= '0;
            base_reg      <= '0;
            drain_reg     <= '0;
            div_cnt_reg   <= '0;
        end
        else
        begin
            p1_reg <= (state_reg == S_SCAN) && in_win;
            p2_reg <= p1_reg && mem_q_reg[SB];
            if (q_pop && e_prod)
            begin
                any_reg <= 1'b0;
            end
            else if (p2_reg)
            begin
                any_reg <= 1'b1;
            end
            out_valid_reg <= load_out || (out_valid_reg && out_stall);
            unique case (state_reg)
                S_IDLE:
                begin
                    if (q_pop && e_prod)
                    begin
                        jrow_reg  <= e_orow;
                        jcol_reg  <= e_ocol;
                        jline_reg <= e_oline;
                        jlast_reg <= e_last;
                        kr_reg    <= '0;
                        kc_reg    <= '0;
                        widx_reg  <= '0;
                        base_reg  <= '0;
                        state_reg <= S_SCAN;
                    end
                end
                S_SCAN:
                begin
                    if (last_pos)
                    begin
                        drain_reg <= '0;
                        state_reg <= S_DRAIN;
                    end
                    else if ((HALF_W+1)'(kc_reg) == {cfg.half_c, 1'b0})
                    begin
                        kc_reg   <= '0;
                        kr_reg   <= kr_reg + 1'b1;
                        base_reg <= base_reg + WI_W'(MAX_KERNEL);
                        widx_reg <= base_reg + WI_W'(MAX_KERNEL);
                    end
                    else
                    begin
                        kc_reg   <= kc_reg + 1'b1;
                        widx_reg <= widx_reg + 1'b1;
                    end
                end
                S_DRAIN:
                begin
                    if (drain_reg == 2'd2)
                    begin
                        ok_reg  <= setup_ok;
                        neg_reg <= setup_neg;
                        if (!setup_ok || !cfg.norm)
                        begin
                            num_reg   <= (NW'(mag) + NW'(1 << (WEIGHT_FRAC - 1))) >> WEIGHT_FRAC;
                            state_reg <= S_DONE;
                        end
                        else
                        begin
                            num_reg     <= {mag, 1'b0} + NW'(den);
                            d_reg       <= {den, 1'b0};
                            rem_reg     <= '0;
                            div_cnt_reg <= DCW'(NW);
                            state_reg   <= S_DIV;
                        end
                    end
                    else
                    begin
                        drain_reg <= drain_reg + 1'b1;
                    end
                end
                S_DIV:
                begin
                    if (rem_sh >= RW'(d_reg))
                    begin
                        rem_reg <= rem_sh - RW'(d_reg);
                        num_reg <= {num_reg[NW-2:0], 1'b1};
                    end
                    else
                    begin
                        rem_reg <= rem_sh;
                        num_reg <= {num_reg[NW-2:0], 1'b0};
                    end
                    div_cnt_reg <= div_cnt_reg - 1'b1;
                    if (div_cnt_reg == DCW'(1))
                    begin
                        state_reg <= S_DONE;
                    end
                end
                S_DONE:
                begin
                    if (load_out)
                    begin
                        state_reg <= S_IDLE;
                    end
                end
                default:
                begin
                    state_reg <= S_IDLE;
                end
            endcase
        end
    end

    always_ff @(posedge clk)
    begin
        if (load_out)
        begin
            sm_reg     <= sat;
            rv_reg     <= ok_reg;
            row_o_reg  <= jrow_reg;
            col_o_reg  <= jcol_reg;
            last_o_reg <= jlast_reg;
        end
    end

    logic [COLW+9:0] col_wide;
    assign col_wide     = {10'd0, col_o_reg};
    assign out_valid    = out_valid_reg;
    assign smoothed     = sm_reg;
    assign result_valid = rv_reg;
    assign out_row      = row_o_reg;
    assign out_col      = col_wide[9:0];
    assign out_last     = last_o_reg;

`ifndef NO_ASSERTIONS
    a_pop_idle: assert property (@(posedge clk) disable iff (!rst_n)
        q_pop |-> state_reg == S_IDLE)
        else $error("queue popped while a window is in progress");
    a_invalid_zero: assert property (@(posedge clk) disable iff (!rst_n)
        (out_valid_reg && !rv_reg) |-> sm_reg == '0)
        else $error("invalid result carries a non-zero value");
    a_div_norm: assert property (@(posedge clk) disable iff (!rst_n)
        (state_reg == S_DIV) |-> cfg.norm)
        else $error("divider running without normalisation");
    a_mac_scan: assert property (@(posedge clk) disable iff (!rst_n)
        p1_reg |-> $past(state_reg) == S_SCAN)
        else $error("window read outside a scan");
`endif

endmodule

@@ rtl/masked_kernel_smoother.sv @@
// Masked kernel smoother: 2-D convolution of one image band (norm optional).
//
// Input channel (in_valid / in_stall): a command per transaction. A weight
// command loads one Q2.14 kernel weight, a pixel command delivers the next
// sample of the band in raster order with its valid mark, and a flush command
// drains the results still pending once the last pixel has gone in.
// Output channel (out_valid / out_stall): one transaction per pixel, in raster
// order, with its row, column, a last mark on the final pixel and a valid mark
// that is low when no neighbour was valid or, with normalisation on, the
// weight sum was zero. The host must write configuration registers through
// cfg_we / cfg_index / cfg_data only while the block is idle; the block does
// not enforce this. Any write to a known register restarts the frame.
//
// A transaction that yields no result is popped by the idle back end. A result
// takes a window scan through the single line-store read port and the shared
// multiply-accumulate, plus, with normalisation on, the serial divider at one
// quotient bit per cycle. A four-entry queue lets input continue while the
// back end works. Reset clears counters, weights and configuration to
// defaults; the line store needs no clearing. A stalled result is held in the
// output register while the back end keeps working on the next one.
module masked_kernel_smoother
    import mks_pkg::*;
#(
    parameter int MAX_COLS    = DEF_MAX_COLS,
    parameter int MAX_KERNEL  = DEF_MAX_KERNEL,
    parameter int SAMPLE_BITS = DEF_SAMPLE_BITS
)
(
    input  logic                   clk,
    input  logic                   rst_n,
    input  logic                   cfg_we,
    input  logic [CFG_IDX_W-1:0]   cfg_index,
    input  logic [CFG_DAT_W-1:0]   cfg_data,
    input  logic                   in_valid,
    output logic                   in_stall,
    input  logic [1:0]             command,
    input  logic [SAMPLE_BITS-1:0] sample,
    input  logic                   sample_valid,
    input  logic [4:0]             weight_index,
    input  logic [15:0]            weight_value,
    output logic                   out_valid,
    input  logic                   out_stall,
    output logic [SAMPLE_BITS-1:0] smoothed,
    output logic                   result_valid,
    output logic [15:0]            out_row,
    output logic [9:0]             out_col,
    output logic                   out_last
);

    localparam int COLW     = $clog2(MAX_COLS);
    localparam int LW       = (MAX_KERNEL > 1) ? $clog2(MAX_KERNEL) : 1;
    localparam int HALF_MAX = (MAX_KERNEL - 1) / 2;
    // Queue entry: op, produce, write line/column, sample, valid, weight
    // index/value, output row/column/line, last.
    localparam int EW = 2 + 1 + LW + COLW + SAMPLE_BITS + 1 + 5 + 16 + 16 + COLW + LW + 1;

    // Raw configuration registers as written by the host.
    logic [15:0] rows_reg;
    logic [10:0] cols_reg;
    logic [1:0]  half_r_reg, half_c_reg;
    logic        norm_reg;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            rows_reg   <= 16'd1;
            cols_reg   <= 11'd1;
            half_r_reg <= 2'd1;
            half_c_reg <= 2'd1;
            norm_reg   <= 1'b0;
        end
        else if (cfg_we)
        begin
            unique case (cfg_index)
                REG_ROWS:   rows_reg   <= cfg_data[15:0];
                REG_COLS:   cols_reg   <= cfg_data[10:0];
                REG_HALF_R: half_r_reg <= cfg_data[1:0];
                REG_HALF_C: half_c_reg <= cfg_data[1:0];
                REG_NORM:   norm_reg   <= cfg_data[0];
                default:    ;
            endcase
        end
    end

    // A write to any listed register restarts the frame counters.
    logic cfg_clear;
    assign cfg_clear = cfg_we && (cfg_index <= REG_NORM);

    // Effective configuration: zero sizes count as one, oversize values clamp.
    cfg_t               cfg;
    logic [HALF_W-1:0]  hr_raw, hc_raw;
    logic [LAG_W:0]     lag_full;

    assign hr_raw = HALF_W'(half_r_reg);
    assign hc_raw = HALF_W'(half_c_reg);

    always_comb
    begin
        cfg.rows = (rows_reg == '0) ? CFG_ROW_W'(1) : rows_reg;
        if (cols_reg == '0)
        begin
            cfg.cols = CFG_COL_W'(1);
        end
        else if (CFG_COL_W'(cols_reg) > CFG_COL_W'(MAX_COLS))
        begin
            cfg.cols = CFG_COL_W'(MAX_COLS);
        end
        else
        begin
            cfg.cols = CFG_COL_W'(cols_reg);
        end
        cfg.half_r = (hr_raw > HALF_W'(HALF_MAX)) ? HALF_W'(HALF_MAX) : hr_raw;
        cfg.half_c = (hc_raw > HALF_W'(HALF_MAX)) ? HALF_W'(HALF_MAX) : hc_raw;
        cfg.norm   = norm_reg;
        // Results trail the input by hr full lines plus hc samples.
        lag_full   = (LAG_W+1)'(cfg.half_r) * (LAG_W+1)'(cfg.cols) + (LAG_W+1)'(cfg.half_c);
        cfg.lag    = lag_full[LAG_W-1:0];
    end

    logic          q_push, q_pop, q_full, q_empty;
    logic [EW-1:0] q_wdata, q_rdata;

    mks_front #(
        .MAX_COLS    (MAX_COLS),
        .MAX_KERNEL  (MAX_KERNEL),
        .SAMPLE_BITS (SAMPLE_BITS),
        .EW          (EW)
    ) u_front (
        .clk          (clk),
        .rst_n        (rst_n),
        .cfg          (cfg),
        .clear        (cfg_clear),
        .in_valid     (in_valid),
        .in_stall     (in_stall),
        .command      (command),
        .sample       (sample),
        .sample_valid (sample_valid),
        .weight_index (weight_index),
        .weight_value (weight_value),
        .q_push       (q_push),
        .q_data       (q_wdata),
        .q_full       (q_full)
    );

    mks_queue #(
        .WIDTH (EW),
        .DEPTH (QUEUE_DEPTH)
    ) u_queue (
        .clk     (clk),
        .rst_n   (rst_n),
        .push    (q_push),
        .wr_data (q_wdata),
        .pop     (q_pop),
        .rd_data (q_rdata),
        .full    (q_full),
        .empty   (q_empty)
    );

    mks_back #(
        .MAX_COLS    (MAX_COLS),
        .MAX_KERNEL  (MAX_KERNEL),
        .SAMPLE_BITS (SAMPLE_BITS),
        .EW          (EW)
    ) u_back (
        .clk          (clk),
        .rst_n        (rst_n),
        .cfg          (cfg),
        .q_empty      (q_empty),
        .q_data       (q_rdata),
        .q_pop        (q_pop),
        .out_valid    (out_valid),
        .out_stall    (out_stall),
        .smoothed     (smoothed),
        .result_valid (result_valid),
        .out_row      (out_row),
        .out_col      (out_col),
        .out_last     (out_last)
    );

endmodule
